/* design/kpsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared constants, types and codes of the keypad scanner.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int ROWS      = 4;
    localparam int COLS      = 4;
    localparam int DEPTH     = 8;

    localparam int KEYS      = ROWS * COLS;
    localparam int MTX_W     = 16;
    localparam int SCAN_BITS = (KEYS < MTX_W) ? KEYS : MTX_W;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int KEY_W     = 4;
    localparam int LAST_W    = 5;
    localparam int HOLD_W    = 12;
    localparam int FILL_W    = 4;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;

    localparam logic [LAST_W-1:0] KEY_NONE  = LAST_W'(16);
    localparam logic [HOLD_W-1:0] HOLD_MAX  = HOLD_W'(4095);

    localparam logic [HOLD_W-1:0] PRESS_RST  = HOLD_W'(6);
    localparam logic [HOLD_W-1:0] FIRST_RST  = HOLD_W'(128);
    localparam logic [HOLD_W-1:0] SECOND_RST = HOLD_W'(256);
    localparam logic [HOLD_W-1:0] WRAP_RST   = HOLD_W'(268);

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_POP   = 2'd1,
        OP_TAKE  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_PRESS  = 2'd0,
        REG_FIRST  = 2'd1,
        REG_SECOND = 2'd2,
        REG_WRAP   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } kpsd_cmd_t;

endpackage
`default_nettype wire

/* design/kpsd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_ctrl
// Handshake controller: captures an item, runs the execute state, holds the
// result until the output transfer.
// ----------------------------------------------------------------------------
module kpsd_ctrl
    import kpsd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output kpsd_cmd_t       cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        s_ready     = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        cmd.capture = s_valid && s_ready;
        cmd.execute = (state_reg == ST_EXEC);
        m_valid     = m_valid_reg;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> m_valid_reg)
        else $error("execute cycle did not load the result");

    a_capture_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("captured item not executed");

    a_exec_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> (!m_valid_reg && !s_ready))
        else $error("execute while result still pending");
`endif

endmodule
`default_nettype wire

/* design/kpsd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_datapath
// Config registers, key encoder, debounce and repeat counter, key FIFO and
// result register.
// ----------------------------------------------------------------------------
module kpsd_datapath
    import kpsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire kpsd_cmd_t           cmd,
    input  wire logic [1:0]          s_op,
    input  wire logic [MTX_W-1:0]    s_key_matrix,
    output logic [KEY_W-1:0]         m_key,
    output logic                     m_key_valid,
    output logic                     m_pushed,
    output logic [FILL_W-1:0]        m_fill_level,
    input  wire logic                cfg_wr,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata
);

    logic [HOLD_W-1:0] press_reg, first_reg, second_reg, wrap_reg;

    op_t               op_reg;
    logic [MTX_W-1:0]  mtx_reg;
    logic [KEY_W-1:0]  rd_data_reg;

    logic [KEY_W-1:0]  key_store [DEPTH];

    logic [LAST_W-1:0] last_key_reg, last_key_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next, tail_inc, head_inc, rd_addr;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [KEY_W-1:0]  m_key_reg, m_key_next;
    logic              m_key_valid_reg, m_key_valid_next;
    logic              m_pushed_reg, m_pushed_next;
    logic [FILL_W-1:0] m_fill_reg;

    logic              found;
    logic [KEY_W-1:0]  found_key;
    logic [HOLD_W-1:0] hold_inc;
    logic              hit, wrap_hit, push;

    reg_idx_t          wr_idx;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_reg  <= PRESS_RST;
            first_reg  <= FIRST_RST;
            second_reg <= SECOND_RST;
            wrap_reg   <= WRAP_RST;
        end else if (cfg_wr) begin
            case (wr_idx)
                REG_PRESS:  press_reg  <= pwdata[HOLD_W-1:0];
                REG_FIRST:  first_reg  <= pwdata[HOLD_W-1:0];
                REG_SECOND: second_reg <= pwdata[HOLD_W-1:0];
                REG_WRAP:   wrap_reg   <= pwdata[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_PRESS:  prdata = DATA_W'(press_reg);
            REG_FIRST:  prdata = DATA_W'(first_reg);
            REG_SECOND: prdata = DATA_W'(second_reg);
            REG_WRAP:   prdata = DATA_W'(wrap_reg);
            default:    prdata = '0;
        endcase
    end

    // lowest set bit = first pressed row, then first pressed column
    always_comb begin
        found     = 1'b0;
        found_key = '0;
        for (int i = SCAN_BITS - 1; i >= 0; i--) begin
            if (mtx_reg[i]) begin
                found     = 1'b1;
                found_key = KEY_W'(i);
            end
        end
    end

    assign tail_inc = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(tail_reg + 1'b1);
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(head_reg + 1'b1);
    assign rd_addr  = (op_t'(s_op) == OP_TAKE) ? tail_reg : head_reg;
    assign hold_inc = (hold_reg < HOLD_MAX) ? HOLD_W'(hold_reg + 1'b1) : hold_reg;
    assign hit      = (hold_inc == press_reg) || (hold_inc == first_reg) ||
                      (hold_inc == second_reg);
    assign wrap_hit = (hold_inc == wrap_reg);

    always_comb begin
        last_key_next    = last_key_reg;
        hold_next        = hold_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cnt_next         = cnt_reg;
        push             = 1'b0;
        m_key_next       = '0;
        m_key_valid_next = 1'b0;
        m_pushed_next    = 1'b0;
        case (op_reg)
            OP_SCAN: begin
                if (cnt_reg != CNT_W'(DEPTH)) begin
                    if (!found) begin
                        last_key_next = KEY_NONE;
                        hold_next     = '0;
                    end else if (LAST_W'(found_key) != last_key_reg) begin
                        last_key_next = LAST_W'(found_key);
                        hold_next     = HOLD_W'(1);
                    end else begin
                        hold_next = (!hit && wrap_hit) ? second_reg : hold_inc;
                        push      = hit || wrap_hit;
                    end
                end
                if (push) begin
                    tail_next     = tail_inc;
                    cnt_next      = CNT_W'(cnt_reg + 1'b1);
                    m_pushed_next = 1'b1;
                end
            end
            OP_POP: begin
                if (cnt_reg != '0) begin
                    m_key_next       = rd_data_reg;
                    m_key_valid_next = 1'b1;
                    head_next        = head_inc;
                    cnt_next         = CNT_W'(cnt_reg - 1'b1);
                end
            end
            OP_TAKE: begin
                if (cnt_reg != '0) begin
                    m_key_next       = rd_data_reg;
                    m_key_valid_next = 1'b1;
                    head_next        = '0;
                    tail_next        = IDX_W'(DEPTH - 1);
                    cnt_next         = '0;
                end
            end
            OP_CLEAR: begin
                head_next = '0;
                tail_next = IDX_W'(DEPTH - 1);
                cnt_next  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= key_store[rd_addr];
        end
        if (cmd.execute && push) begin
            key_store[tail_inc] <= found_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= op_t'(s_op);
            mtx_reg <= s_key_matrix;
        end
        if (cmd.execute) begin
            m_key_reg       <= m_key_next;
            m_key_valid_reg <= m_key_valid_next;
            m_pushed_reg    <= m_pushed_next;
            m_fill_reg      <= FILL_W'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_key_reg <= '0;
            hold_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= IDX_W'(DEPTH - 1);
            cnt_reg      <= '0;
        end else if (cmd.execute) begin
            last_key_reg <= last_key_next;
            hold_reg     <= hold_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
        end
    end

    assign m_key        = m_key_reg;
    assign m_key_valid  = m_key_valid_reg;
    assign m_pushed     = m_pushed_reg;
    assign m_fill_level = m_fill_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("FIFO count beyond depth");

    a_push_xor_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && m_pushed_next) |-> !m_key_valid_next)
        else $error("push and read in one item");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && (op_reg == OP_CLEAR)) |=> (cnt_reg == '0))
        else $error("clear left entries in FIFO");
`endif

endmodule
`default_nettype wire

/* design/keypad_scan_debounce_repeat_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// An input transfer leads to the execute state, which loads the result and
// m_valid; no new item is taken while one executes. The key store read is
// registered in the capture cycle and the FIFO/debounce update happens in
// the execute cycle. A pending result holds in the output register while
// the next item waits. Reset (synchronous, active low) restores config
// defaults, debounce state and FIFO pointers; key store is not cleared.
// ----------------------------------------------------------------------------
// keypad_scan_debounce_repeat_fifo
// Matrix keypad scanner with debounce, auto-repeat and a key FIFO.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_repeat_fifo
    import kpsd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic [MTX_W-1:0]   s_key_matrix,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [KEY_W-1:0]        m_key,
    output logic                    m_key_valid,
    output logic                    m_pushed,
    output logic [FILL_W-1:0]       m_fill_level,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    kpsd_cmd_t cmd;
    logic      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    kpsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    kpsd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_op         (s_op),
        .s_key_matrix (s_key_matrix),
        .m_key        (m_key),
        .m_key_valid  (m_key_valid),
        .m_pushed     (m_pushed),
        .m_fill_level (m_fill_level),
        .cfg_wr       (cfg_wr),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata)
    );

endmodule
`default_nettype wire
